// File: rtl/core/vas_pkg.sv
// ----------------------------------------------------------------------------
// vas_pkg
// Shared types, codes and constants of the valve actuator sequencer.
// ----------------------------------------------------------------------------
package vas_pkg;

    // command codes
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_OPEN      = 3'd1;
    localparam logic [2:0] OP_CLOSE     = 3'd2;
    localparam logic [2:0] OP_TOGGLE    = 3'd3;
    localparam logic [2:0] OP_REFRESH   = 3'd4;
    localparam logic [2:0] OP_BARREL_MT = 3'd5;
    localparam logic [2:0] OP_BARREL_FL = 3'd6;

    // motion phase
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_OPENING = 2'd1;
    localparam logic [1:0] PH_CLOSING = 2'd2;

    // reported position
    localparam logic [1:0] POS_MOVING = 2'd0;
    localparam logic [1:0] POS_OPEN   = 2'd1;
    localparam logic [1:0] POS_CLOSED = 2'd2;

    // fault codes
    localparam logic [1:0] FLT_OK         = 2'd0;
    localparam logic [1:0] FLT_NOT_OPEN   = 2'd1;
    localparam logic [1:0] FLT_NOT_CLOSED = 2'd2;

    // refresh sequence phase
    localparam logic [1:0] RF_NONE = 2'd0;
    localparam logic [1:0] RF_AWAY = 2'd1;
    localparam logic [1:0] RF_BACK = 2'd2;

    // end switch decode, indexed [closed_limit][open_limit]
    localparam logic [2:0] SW_UNDEF  = 3'd0;
    localparam logic [2:0] SW_OPEN   = 3'd1;
    localparam logic [2:0] SW_CLOSED = 3'd2;
    localparam logic [2:0] SW_BROKEN = 3'd4;
    localparam logic [2:0] SWITCH_CODE [0:1][0:1] = '{
        '{SW_UNDEF,  SW_OPEN},
        '{SW_CLOSED, SW_BROKEN}
    };

    // configuration register indexes
    localparam int unsigned CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MOVE_TIMEOUT = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AUTO_OPEN    = 1'd1;
    localparam int unsigned CFG_DATA_BITS  = 16;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd20000;

    typedef struct packed {
        logic [2:0] opcode;
        logic       open_limit;
        logic       closed_limit;
    } vas_in_t;

    typedef struct packed {
        logic       open_drive;
        logic       close_drive;
        logic [1:0] valve_position;
        logic [1:0] fault_code;
        logic       move_done;
        logic       refresh_busy;
    } vas_out_t;

    // control state, the move timer travels beside it
    typedef struct packed {
        logic [1:0] motion_phase;
        logic [1:0] position;
        logic [1:0] fault;
        logic [1:0] refresh_phase;
        logic       refresh_started_open;
    } vas_ctrl_t;

    typedef struct packed {
        logic [15:0] move_timeout_ticks;
        logic        auto_open_enable;
    } vas_cfg_t;

endpackage

// File: rtl/core/vas_cfg_regs.sv
// ----------------------------------------------------------------------------
// vas_cfg_regs
// Configuration register file: index decode and write of the two registers.
// ----------------------------------------------------------------------------
module vas_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 wr_en,
    input  logic [vas_pkg::CFG_INDEX_BITS-1:0]   wr_index,
    input  logic [vas_pkg::CFG_DATA_BITS-1:0]    wr_data,
    output vas_pkg::vas_cfg_t                    cfg
);

    vas_pkg::vas_cfg_t cfg_reg;
    vas_pkg::vas_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                vas_pkg::CFG_MOVE_TIMEOUT: cfg_next.move_timeout_ticks = wr_data[15:0];
                vas_pkg::CFG_AUTO_OPEN:    cfg_next.auto_open_enable   = wr_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.move_timeout_ticks <= vas_pkg::TIMEOUT_RESET;
            cfg_reg.auto_open_enable   <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/vas_step.sv
// ----------------------------------------------------------------------------
// vas_step
// Next-state logic for one tick: command decode, then move supervision.
// ----------------------------------------------------------------------------
module vas_step #(
    parameter int unsigned TIMER_BITS = 16
) (
    input  vas_pkg::vas_in_t        item,
    input  vas_pkg::vas_cfg_t       cfg,
    input  vas_pkg::vas_ctrl_t      ctrl,
    input  logic [TIMER_BITS-1:0]   elapsed,
    output vas_pkg::vas_ctrl_t      ctrl_next,
    output logic [TIMER_BITS-1:0]   elapsed_next,
    output vas_pkg::vas_out_t       result
);

    localparam int unsigned CMP_BITS = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    vas_pkg::vas_ctrl_t    c1;
    logic [TIMER_BITS-1:0] el1;
    logic                  start;
    logic                  start_open;
    logic                  from_open;
    logic [2:0]            sw_code;
    logic                  to_open;
    logic                  reached;
    logic                  expired;
    logic                  done;

    assign sw_code   = vas_pkg::SWITCH_CODE[item.closed_limit][item.open_limit];
    assign from_open = (sw_code == vas_pkg::SW_UNDEF) || (sw_code == vas_pkg::SW_OPEN);

    // command stage
    always_comb begin
        c1         = ctrl;
        el1        = elapsed;
        start      = 1'b0;
        start_open = 1'b0;
        if (c1.refresh_phase == 2'd3) begin
            c1.refresh_phase = vas_pkg::RF_NONE;
        end
        unique case (item.opcode)
            vas_pkg::OP_OPEN: begin
                start = 1'b1;
                start_open = 1'b1;
                c1.refresh_phase = vas_pkg::RF_NONE;
            end
            vas_pkg::OP_CLOSE, vas_pkg::OP_BARREL_FL: begin
                start = 1'b1;
                c1.refresh_phase = vas_pkg::RF_NONE;
            end
            vas_pkg::OP_TOGGLE: begin
                start = 1'b1;
                start_open = (ctrl.position == vas_pkg::POS_CLOSED);
                c1.refresh_phase = vas_pkg::RF_NONE;
            end
            vas_pkg::OP_REFRESH: begin
                start = 1'b1;
                start_open = !from_open;
                c1.refresh_phase = vas_pkg::RF_AWAY;
                c1.refresh_started_open = from_open;
            end
            vas_pkg::OP_BARREL_MT: begin
                if (cfg.auto_open_enable && item.closed_limit) begin
                    start = 1'b1;
                    start_open = 1'b1;
                    c1.refresh_phase = vas_pkg::RF_NONE;
                end
            end
            default: ;
        endcase
        if (start) begin
            c1.motion_phase = start_open ? vas_pkg::PH_OPENING : vas_pkg::PH_CLOSING;
            c1.position     = vas_pkg::POS_MOVING;
            c1.fault        = vas_pkg::FLT_OK;
            el1             = '0;
        end
    end

    assign to_open = (c1.motion_phase == vas_pkg::PH_OPENING);
    assign reached = to_open ? item.open_limit : item.closed_limit;
    assign expired = (CMP_BITS'(el1) >= CMP_BITS'(cfg.move_timeout_ticks)) || (&el1);

    // supervision stage
    always_comb begin
        ctrl_next    = c1;
        elapsed_next = el1;
        done         = 1'b0;
        if ((c1.motion_phase == vas_pkg::PH_OPENING) ||
            (c1.motion_phase == vas_pkg::PH_CLOSING)) begin
            if (reached || expired) begin
                done = 1'b1;
                ctrl_next.fault = reached ? vas_pkg::FLT_OK :
                                  (to_open ? vas_pkg::FLT_NOT_OPEN : vas_pkg::FLT_NOT_CLOSED);
                ctrl_next.position = to_open ? vas_pkg::POS_OPEN : vas_pkg::POS_CLOSED;
                ctrl_next.motion_phase = vas_pkg::PH_IDLE;
                if (c1.refresh_phase == vas_pkg::RF_AWAY) begin
                    // return leg starts now, first checked next tick
                    ctrl_next.refresh_phase = vas_pkg::RF_BACK;
                    ctrl_next.motion_phase  = c1.refresh_started_open ?
                                              vas_pkg::PH_OPENING : vas_pkg::PH_CLOSING;
                    ctrl_next.position      = vas_pkg::POS_MOVING;
                    ctrl_next.fault         = vas_pkg::FLT_OK;
                    elapsed_next            = '0;
                end else if (c1.refresh_phase == vas_pkg::RF_BACK) begin
                    ctrl_next.refresh_phase = vas_pkg::RF_NONE;
                end
            end else begin
                elapsed_next = el1 + 1'b1;
            end
        end else begin
            ctrl_next.motion_phase = vas_pkg::PH_IDLE;
        end
    end

    always_comb begin
        result.open_drive     = (ctrl_next.motion_phase == vas_pkg::PH_OPENING);
        result.close_drive    = (ctrl_next.motion_phase == vas_pkg::PH_CLOSING);
        result.valve_position = ctrl_next.position;
        result.fault_code     = ctrl_next.fault;
        result.move_done      = done;
        result.refresh_busy   = (ctrl_next.refresh_phase != vas_pkg::RF_NONE);
    end

endmodule

// File: rtl/core/valve_actuator_sequencer_unit.sv
// ----------------------------------------------------------------------------
// valve_actuator_sequencer_unit
// Motorized valve sequencer: one timer tick per input transfer, one status
// result per tick.
// ----------------------------------------------------------------------------
//  channel  | ports                              | carries
//  ---------+------------------------------------+--------------------------------
//  input    | s_valid s_ready s_data             | command + end switch samples
//  result   | m_valid m_ready m_data             | drives, position, fault, flags
//  config   | cfg_valid cfg_ready cfg_index/data | timeout, auto-open enable
//
// One tick per cycle unless stalled: the whole tick (command, then move check)
// is settled by vas_step between the state registers and the result register,
// so the result shows in the cycle after its transfer.
// The result register holds a stalled result; s_ready is low only while it is
// full and not being taken, so input and output stall together.
// Reset (aresetn, synchronous) idles the valve, position moving, fault ok, no
// refresh, timeout 20000, auto-open on. Config writes are always taken.
// ----------------------------------------------------------------------------
module valve_actuator_sequencer_unit #(
    parameter int unsigned TIMER_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  vas_pkg::vas_in_t                    s_data,

    output logic                                m_valid,
    input  logic                                m_ready,
    output vas_pkg::vas_out_t                   m_data,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vas_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [vas_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    vas_pkg::vas_cfg_t     cfg;
    vas_pkg::vas_ctrl_t    ctrl_reg;
    vas_pkg::vas_ctrl_t    ctrl_next;
    logic [TIMER_BITS-1:0] elapsed_reg;
    logic [TIMER_BITS-1:0] elapsed_next;
    vas_pkg::vas_out_t     result;
    vas_pkg::vas_out_t     out_reg;
    logic                  out_valid_reg;
    logic                  in_xfer;

    assign cfg_ready = 1'b1;

    vas_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    vas_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .item         (s_data),
        .cfg          (cfg),
        .ctrl         (ctrl_reg),
        .elapsed      (elapsed_reg),
        .ctrl_next    (ctrl_next),
        .elapsed_next (elapsed_next),
        .result       (result)
    );

    // room when empty or the held result leaves this cycle
    assign s_ready = !out_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;

    // state advances only on an accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.motion_phase         <= vas_pkg::PH_IDLE;
            ctrl_reg.position             <= vas_pkg::POS_MOVING;
            ctrl_reg.fault                <= vas_pkg::FLT_OK;
            ctrl_reg.refresh_phase        <= vas_pkg::RF_NONE;
            ctrl_reg.refresh_started_open <= 1'b0;
            elapsed_reg                   <= '0;
        end else if (in_xfer) begin
            ctrl_reg    <= ctrl_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // never drive both directions at once
    a_one_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.open_drive && m_data.close_drive))
        else $error("open and close driven together");

    // a driven actuator always reports moving
    a_drive_moving: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.open_drive || m_data.close_drive)) |->
        (m_data.valve_position == vas_pkg::POS_MOVING))
        else $error("drive active while position settled");

    // a fault is only shown with a settled position
    a_fault_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.fault_code != vas_pkg::FLT_OK)) |->
        (m_data.valve_position != vas_pkg::POS_MOVING))
        else $error("fault reported while moving");

    // every accepted tick yields a result next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted tick produced no result");

endmodule

// File: tb/valve_actuator_sequencer_unit_tb.sv
// ----------------------------------------------------------------------------
// valve_actuator_sequencer_unit_tb
// Self-checking bench for the valve sequencer. Ticks go into the block through
// a queue-fed driver with random bursts and gaps. Every accepted tick is run
// through a behavioral copy of the sequencer, and each returned status is
// matched against the oldest predicted one. The run opens with a directed
// walk through the commands and corner cases, then does one long move that
// ends on its timeout and several randomized phases at different settings.
// ----------------------------------------------------------------------------
module valve_actuator_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TMR_BITS = 16;
    localparam logic [TMR_BITS-1:0] TMR_MAX = {TMR_BITS{1'b1}};
    localparam logic [2:0] OP_UNUSED = 3'd7;    // decodes as a plain tick
    localparam int IDLE_LIMIT = 5000;           // cycles with no transfer at all
    localparam int HOLD_CYCLES = 200;           // long receiver back-pressure
    localparam int REPORT_MAX = 10;

    typedef enum logic [1:0] {RX_FREE, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_t;

    // ------------------------------------------------------------------------
    // DUT hookup; every input holds a known value from time zero
    // ------------------------------------------------------------------------
    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    vas_pkg::vas_in_t   s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    vas_pkg::vas_out_t  m_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [vas_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [vas_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    valve_actuator_sequencer_unit #(
        .TIMER_BITS(TMR_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    vas_pkg::vas_in_t  tick_q[$];        // ticks waiting for the driver
    vas_pkg::vas_out_t status_q[$];      // predicted status, oldest first
    int       n_fail = 0;
    bit       tick_taken = 0;   // set at the edge where the driver's tick transferred
    bit       hold_req = 0;     // asks the receiver for one long hold-off
    int       idle_cycles = 0;

    // Shadow of the sequencer: registers and control state
    logic [15:0]         mirror_timeout = vas_pkg::TIMEOUT_RESET;
    logic                mirror_auto = 1'b1;
    logic [1:0]          vm_phase = vas_pkg::PH_IDLE;
    logic [TMR_BITS-1:0] vm_elapsed = '0;
    logic [1:0]          vm_position = vas_pkg::POS_MOVING;
    logic [1:0]          vm_fault = vas_pkg::FLT_OK;
    logic [1:0]          vm_refresh = vas_pkg::RF_NONE;
    logic                vm_refresh_open = 1'b0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    task automatic begin_move(input logic to_open);
        vm_phase = to_open ? vas_pkg::PH_OPENING : vas_pkg::PH_CLOSING;
        vm_elapsed = '0;
        vm_position = vas_pkg::POS_MOVING;
        vm_fault = vas_pkg::FLT_OK;
    endtask

    // One tick: the command acts first, then the running move is checked on
    // the same tick. A return move started here is first checked next tick.
    task automatic advance_valve(input vas_pkg::vas_in_t t, output vas_pkg::vas_out_t r);
        logic to_open;
        logic reached;
        logic expired;
        logic done;
        logic from_open;
        done = 1'b0;
        if (vm_refresh != vas_pkg::RF_AWAY && vm_refresh != vas_pkg::RF_BACK)
            vm_refresh = vas_pkg::RF_NONE;

        case (t.opcode)
            vas_pkg::OP_OPEN: begin
                vm_refresh = vas_pkg::RF_NONE;
                begin_move(1'b1);
            end
            vas_pkg::OP_CLOSE, vas_pkg::OP_BARREL_FL: begin
                vm_refresh = vas_pkg::RF_NONE;
                begin_move(1'b0);
            end
            vas_pkg::OP_TOGGLE: begin
                vm_refresh = vas_pkg::RF_NONE;
                begin_move(vm_position == vas_pkg::POS_CLOSED);
            end
            vas_pkg::OP_REFRESH: begin
                // undefined or open-only counts as the open end; closed-only
                // and the broken both-active case count as the closed end
                from_open = !t.closed_limit;
                vm_refresh_open = from_open;
                vm_refresh = vas_pkg::RF_AWAY;
                begin_move(!from_open);
            end
            vas_pkg::OP_BARREL_MT: begin
                // refused unless enabled and sitting on the closed switch
                if (mirror_auto && t.closed_limit) begin
                    vm_refresh = vas_pkg::RF_NONE;
                    begin_move(1'b1);
                end
            end
            default: ;
        endcase

        if (vm_phase == vas_pkg::PH_OPENING || vm_phase == vas_pkg::PH_CLOSING) begin
            to_open = (vm_phase == vas_pkg::PH_OPENING);
            reached = to_open ? t.open_limit : t.closed_limit;
            expired = (vm_elapsed >= mirror_timeout) || (vm_elapsed == TMR_MAX);
            if (reached || expired) begin
                done = 1'b1;
                vm_fault = reached ? vas_pkg::FLT_OK :
                           (to_open ? vas_pkg::FLT_NOT_OPEN : vas_pkg::FLT_NOT_CLOSED);
                vm_position = to_open ? vas_pkg::POS_OPEN : vas_pkg::POS_CLOSED;
                vm_phase = vas_pkg::PH_IDLE;
                if (vm_refresh == vas_pkg::RF_AWAY) begin
                    vm_refresh = vas_pkg::RF_BACK;
                    begin_move(vm_refresh_open);
                end else if (vm_refresh == vas_pkg::RF_BACK) begin
                    vm_refresh = vas_pkg::RF_NONE;
                end
            end else begin
                vm_elapsed = vm_elapsed + 1'b1;
            end
        end else begin
            vm_phase = vas_pkg::PH_IDLE;
        end

        r.open_drive = (vm_phase == vas_pkg::PH_OPENING);
        r.close_drive = (vm_phase == vas_pkg::PH_CLOSING);
        r.valve_position = vm_position;
        r.fault_code = vm_fault;
        r.move_done = done;
        r.refresh_busy = (vm_refresh != vas_pkg::RF_NONE);
    endtask

    function automatic string fmt_status(input vas_pkg::vas_out_t v);
        return $sformatf("open=%0b close=%0b pos=%0d fault=%0d done=%0b refresh=%0b",
                         v.open_drive, v.close_drive, v.valve_position, v.fault_code,
                         v.move_done, v.refresh_busy);
    endfunction

    task automatic note_failure(input string msg);
        n_fail++;
        if (n_fail <= REPORT_MAX)
            $display("%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // Driver: pops ticks at the falling edge, bursts with random gaps between.
    // The rising-edge half predicts each tick as it transfers.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        vas_pkg::vas_out_t predicted;
        if (aresetn && s_valid && s_ready) begin
            advance_valve(s_data, predicted);
            status_q.push_back(predicted);
            tick_taken = 1;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || tick_taken) begin
            tick_taken = 0;
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (tick_q.size() > 0) begin
                s_data <= tick_q.pop_front();
                s_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    // about a third of bursts run straight into the next one
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready pattern moves between four random modes; one long
    // hold-off on request lets the result register fill and stall the input.
    // ------------------------------------------------------------------------
    rx_mode_t rx_mode = RX_FREE;
    int       mode_left = 0;
    int       hold_left = 0;

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 0;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 64);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_FREE:   m_ready <= 1'b1;
                RX_HALF:   m_ready <= ($urandom_range(0, 1) == 1);
                RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                default:   m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: each status transfer is checked field by field against the
    // oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        vas_pkg::vas_out_t got;
        vas_pkg::vas_out_t want;
        if (aresetn && m_valid && m_ready) begin
            got = m_data;
            if (status_q.size() == 0) begin
                note_failure($sformatf("status with nothing predicted: %s", fmt_status(got)));
            end else begin
                want = status_q.pop_front();
                if (got.open_drive !== want.open_drive ||
                    got.close_drive !== want.close_drive ||
                    got.valve_position !== want.valve_position ||
                    got.fault_code !== want.fault_code ||
                    got.move_done !== want.move_done ||
                    got.refresh_busy !== want.refresh_busy)
                    note_failure($sformatf("status mismatch: expected %s, got %s",
                                           fmt_status(want), fmt_status(got)));
            end
        end
    end

    // Register shadow follows the write channel
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                vas_pkg::CFG_MOVE_TIMEOUT: mirror_timeout = cfg_data;
                vas_pkg::CFG_AUTO_OPEN:    mirror_auto = cfg_data[0];
                default: ;
            endcase
        end
    end

    // Watchdog: too long without any transfer on any channel ends the run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("** valve_actuator_sequencer_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_tick(input logic [2:0] op, input logic o, input logic c);
        vas_pkg::vas_in_t t;
        t.opcode = op;
        t.open_limit = o;
        t.closed_limit = c;
        tick_q.push_back(t);
    endtask

    // Waits until every queued tick has transferred and every status is back
    task automatic drain();
        do
            @(negedge aclk);
        while (tick_q.size() != 0 || s_valid || status_q.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [vas_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [15:0] tmo, input logic auto_en);
        write_reg(vas_pkg::CFG_MOVE_TIMEOUT, tmo);
        write_reg(vas_pkg::CFG_AUTO_OPEN, {15'd0, auto_en});
    endtask

    // A move in flight: switch-free ticks (the far switch may chatter), then
    // usually the target switch. Skipping the arrival leaves the move to be
    // preempted by whatever comes next.
    task automatic queue_travel(input logic to_open, input int span, inout int cnt);
        int  n;
        int  k;
        int  r;
        logic o;
        logic c;
        n = $urandom_range(0, span);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                o = to_open ? 1'b0 : 1'($urandom_range(0, 1));
                c = to_open ? 1'($urandom_range(0, 1)) : 1'b0;
            end else begin
                o = 1'b0;
                c = 1'b0;
            end
            queue_tick(vas_pkg::OP_TICK, o, c);
        end
        cnt += n;
        if ($urandom_range(0, 99) < 15)
            return;
        r = $urandom_range(0, 19);
        if (r < 16) begin
            o = to_open;
            c = !to_open;
        end else if (r < 18) begin
            o = 1'b1;
            c = 1'b1;
        end else begin
            o = 1'($urandom_range(0, 1));
            c = 1'($urandom_range(0, 1));
        end
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++)
            queue_tick(vas_pkg::OP_TICK, o, c);
        cnt += n;
    endtask

    // One command with its travel; a slice of plain noise now and then
    task automatic queue_sequence(input int span, inout int cnt);
        int         k;
        int         n;
        logic [2:0] op;
        logic       o;
        logic       c;
        logic       target;
        if ($urandom_range(0, 99) < 12) begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
                queue_tick(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            cnt += n;
            return;
        end
        op = 3'($urandom_range(vas_pkg::OP_OPEN, vas_pkg::OP_BARREL_FL));
        o = 1'($urandom_range(0, 1));
        c = 1'($urandom_range(0, 1));
        if (op == vas_pkg::OP_BARREL_MT && $urandom_range(0, 4) != 0)
            c = 1'b1;
        case (op)
            vas_pkg::OP_OPEN, vas_pkg::OP_BARREL_MT: target = 1'b1;
            vas_pkg::OP_CLOSE, vas_pkg::OP_BARREL_FL: target = 1'b0;
            vas_pkg::OP_TOGGLE: target = c;
            default: target = c;     // refresh heads away from its start end
        endcase
        queue_tick(op, o, c);
        cnt++;
        queue_travel(target, span, cnt);
        if (op == vas_pkg::OP_REFRESH)
            queue_travel(!target, span, cnt);
    endtask

    task automatic run_random(input logic [15:0] tmo, input logic auto_en, input int items,
                              input bit squeeze);
        int cnt;
        int span;
        cnt = 0;
        span = (tmo < 22) ? int'(tmo) + 2 : 24;
        set_regs(tmo, auto_en);
        while (cnt < items)
            queue_sequence(span, cnt);
        if (squeeze)
            hold_req = 1;
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int k;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed, reset settings: timeout 20000, auto-open on
        queue_tick(vas_pkg::OP_TICK, 1'b0, 1'b0);
        queue_tick(vas_pkg::OP_TICK, 1'b1, 1'b1);
        queue_tick(vas_pkg::OP_OPEN, 1'b0, 1'b0);
        queue_tick(vas_pkg::OP_TICK, 1'b1, 1'b0);        // open switch ends the move
        queue_tick(vas_pkg::OP_CLOSE, 1'b1, 1'b0);
        queue_tick(vas_pkg::OP_TICK, 1'b0, 1'b1);
        queue_tick(vas_pkg::OP_TOGGLE, 1'b0, 1'b1);      // closed -> opens
        queue_tick(vas_pkg::OP_TICK, 1'b1, 1'b0);
        queue_tick(vas_pkg::OP_TOGGLE, 1'b1, 1'b0);      // open -> closes
        queue_tick(vas_pkg::OP_OPEN, 1'b1, 1'b0);        // preempts, ends on the same tick
        queue_tick(vas_pkg::OP_REFRESH, 1'b0, 1'b0);     // no switch: treated as open end
        queue_tick(vas_pkg::OP_TICK, 1'b0, 1'b1);        // away leg done, return starts
        queue_tick(vas_pkg::OP_TICK, 1'b1, 1'b0);
        queue_tick(vas_pkg::OP_REFRESH, 1'b0, 1'b1);     // from closed: opens first
        queue_tick(vas_pkg::OP_OPEN, 1'b0, 1'b0);        // plain command cancels refresh
        queue_tick(vas_pkg::OP_REFRESH, 1'b1, 1'b1);     // both switches: counts as closed
        queue_tick(vas_pkg::OP_REFRESH, 1'b1, 1'b0);     // refresh restarts a refresh
        queue_tick(vas_pkg::OP_BARREL_MT, 1'b0, 1'b1);   // accepted, cancels refresh
        queue_tick(vas_pkg::OP_TICK, 1'b1, 1'b0);
        queue_tick(vas_pkg::OP_BARREL_MT, 1'b1, 1'b0);   // refused: not on closed switch
        queue_tick(vas_pkg::OP_BARREL_FL, 1'b0, 1'b1);
        queue_tick(OP_UNUSED, 1'b1, 1'b1);
        queue_tick(vas_pkg::OP_TICK, 1'b0, 1'b0);
        drain();

        // Zero timeout: unswitched moves fault at once; auto-open disabled
        set_regs(16'd0, 1'b0);
        queue_tick(vas_pkg::OP_OPEN, 1'b0, 1'b0);
        queue_tick(vas_pkg::OP_CLOSE, 1'b0, 1'b0);
        queue_tick(vas_pkg::OP_BARREL_MT, 1'b0, 1'b1);   // refused while disabled
        queue_tick(vas_pkg::OP_REFRESH, 1'b0, 1'b0);     // away fault hidden by the return
        queue_tick(vas_pkg::OP_TICK, 1'b0, 1'b0);
        queue_tick(vas_pkg::OP_TOGGLE, 1'b0, 1'b0);
        queue_tick(vas_pkg::OP_TICK, 1'b0, 1'b0);
        drain();

        // Long move that runs out its timeout
        set_regs(16'd200, 1'b1);
        queue_tick(vas_pkg::OP_OPEN, 1'b0, 1'b0);
        for (k = 0; k < 200 + 2; k++)
            queue_tick(vas_pkg::OP_TICK, 1'b0, 1'b0);
        drain();

        // Randomized phases across settings; two of them take the long stall
        run_random(16'd1, 1'b1, 160, 1'b0);
        run_random(16'd3, 1'b0, 160, 1'b1);
        run_random(16'd7, 1'b1, 160, 1'b0);
        run_random(16'($urandom_range(2, 30)), 1'($urandom_range(0, 1)), 160, 1'b0);
        run_random(16'd20000, 1'b1, 160, 1'b1);
        run_random(16'hFFFF, 1'b0, 160, 1'b0);
        run_random(16'd0, 1'b1, 160, 1'b0);

        repeat (10) @(negedge aclk);
        if (status_q.size() != 0)
            note_failure($sformatf("%0d predicted status never returned", status_q.size()));
        if (n_fail == 0) begin
            $display("** valve_actuator_sequencer_unit: PASSED **");
        end else begin
            $display("%0d failures", n_fail);
            $display("** valve_actuator_sequencer_unit: FAILED **");
        end
        $finish;
    end

endmodule
